// ----- src/irct_pkg.sv -----
package irct_pkg;

   // DPX layouts, in the order of the pixel_format register
   typedef enum logic [3:0] {
      FMT_RGB8           = 4'd0,
      FMT_RGB10_LE       = 4'd1,
      FMT_RGB10_BE       = 4'd2,
      FMT_RGB12_PACK_BE  = 4'd3,
      FMT_RGB12_FILL_BE  = 4'd4,
      FMT_RGB12_FILL_LE  = 4'd5,
      FMT_RGB16_BE       = 4'd6,
      FMT_RGB16_LE       = 4'd7,
      FMT_RGBA8          = 4'd8,
      FMT_RGBA10_LE      = 4'd9,
      FMT_RGBA10_BE      = 4'd10,
      FMT_RGBA12_PACK_BE = 4'd11,
      FMT_RGBA12_FILL_BE = 4'd12,
      FMT_RGBA12_FILL_LE = 4'd13,
      FMT_RGBA16_BE      = 4'd14,
      FMT_RGBA16_LE      = 4'd15
   } fmt_type;

   localparam logic       CSR_SAMPLE_BITS   = 1'b0;
   localparam logic       CSR_PIXEL_FORMAT  = 1'b1;
   localparam logic [4:0] SAMPLE_BITS_RESET = 5'd10;
   localparam fmt_type    FMT_RESET         = FMT_RGB10_LE;

   // Pixel after offset removal and the luma correction, before b += g and r += g
   typedef struct packed {
      logic [15:0] g;
      logic [15:0] b_diff;
      logic [15:0] r_diff;
      logic [15:0] a;
      fmt_type     fmt;
      logic        eol;
   } pixel_type;

   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        eol;
   } result_type;

   function automatic logic [15:0] comp_mask(input fmt_type fmt);
      logic [15:0] m;
      unique case (fmt[2:0])
         3'd0:             m = 16'h00FF;
         3'd1, 3'd2:       m = 16'h03FF;
         3'd3, 3'd4, 3'd5: m = 16'h0FFF;
         default:          m = 16'hFFFF;
      endcase
      return m;
   endfunction

   // Word to memory order, byte zero in bits 7:0
   function automatic logic [31:0] mem32(input logic [31:0] c, input logic be);
      return be ? {c[7:0], c[15:8], c[23:16], c[31:24]} : c;
   endfunction

   function automatic logic [15:0] mem16(input logic [15:0] c, input logic be);
      return be ? {c[7:0], c[15:8]} : c;
   endfunction

endpackage

// ----- src/irct_front.sv -----
module irct_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [4:0]          csr_wdata,
   input  logic [15:0]         g_sample,
   input  logic [16:0]         b_sample,
   input  logic [16:0]         r_sample,
   input  logic [15:0]         a_sample,
   input  logic                eol,
   output irct_pkg::pixel_type pixel
);
   import irct_pkg::*;

   logic [4:0]  sample_bits_ff;
   fmt_type     pixel_format_ff;
   logic [17:0] offset;
   logic [17:0] b18;
   logic [17:0] r18;
   logic [17:0] sum18;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bits_ff  <= SAMPLE_BITS_RESET;
         pixel_format_ff <= FMT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SAMPLE_BITS) begin
            sample_bits_ff <= csr_wdata;
         end else begin
            pixel_format_ff <= fmt_type'(csr_wdata[3:0]);
         end
      end
   end

   // Only the low 18 bits of the sum reach the masked components, so work modulo 2^18;
   // an offset of 2^18 or more vanishes there.
   always_comb begin
      offset       = 18'd1 << sample_bits_ff;
      b18          = {1'b0, b_sample} - offset;
      r18          = {1'b0, r_sample} - offset;
      sum18        = b18 + r18;
      pixel.g      = g_sample - sum18[17:2];
      pixel.b_diff = b18[15:0];
      pixel.r_diff = r18[15:0];
      pixel.a      = a_sample;
      pixel.fmt    = pixel_format_ff;
      pixel.eol    = eol;
   end

endmodule

// ----- src/irct_pix_queue.sv -----
module irct_pix_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  irct_pkg::pixel_type push_item,
   output logic                full,
   input  logic                pop,
   output irct_pkg::pixel_type head,
   output logic                empty
);
   import irct_pkg::*;

   pixel_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/irct_packer.sv -----
module irct_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  irct_pkg::pixel_type  head,
   input  logic                 head_empty,
   output logic                 head_pop,
   output irct_pkg::result_type rsp_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);
   import irct_pkg::*;

   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [31:0] carry_ff;
   logic [31:0] carry_in;
   result_type  obuf_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        obuf_full;
   logic        do_rsp_pop;
   result_type  res;

   logic [15:0] mask;
   logic [15:0] rc;
   logic [15:0] gc;
   logic [15:0] bc;
   logic [15:0] ac;
   logic [31:0] r32;
   logic [31:0] g32;
   logic [31:0] b32;
   logic [31:0] a32;
   logic [31:0] c1;
   logic [31:0] c2;
   logic [1:0]  ph3;
   logic        be;

   assign obuf_full  = (count_ff == 2'd2);
   assign rsp_empty  = (count_ff == 2'd0);
   assign rsp_item   = obuf_ff[rd_ptr_ff];
   assign head_pop   = !head_empty && !obuf_full;
   assign do_rsp_pop = rsp_pop && !rsp_empty;

   always_comb begin
      mask     = comp_mask(head.fmt);
      rc       = (head.r_diff + head.g) & mask;
      gc       = head.g & mask;
      bc       = (head.b_diff + head.g) & mask;
      ac       = head.a & mask;
      r32      = {16'd0, rc};
      g32      = {16'd0, gc};
      b32      = {16'd0, bc};
      a32      = {16'd0, ac};
      c1       = 32'd0;
      c2       = 32'd0;
      ph3      = 2'd0;
      be       = 1'b0;
      phase_in = phase_ff;
      carry_in = carry_ff;
      res      = '0;
      res.eol  = head.eol;

      unique case (head.fmt)
         FMT_RGB8: begin
            res.bytes = {40'd0, bc[7:0], gc[7:0], rc[7:0]};
            res.count = 4'd3;
         end
         FMT_RGBA8: begin
            res.bytes = {32'd0, ac[7:0], bc[7:0], gc[7:0], rc[7:0]};
            res.count = 4'd4;
         end
         FMT_RGB10_LE, FMT_RGB10_BE: begin
            be        = (head.fmt == FMT_RGB10_BE);
            c1        = (r32 << 22) | (b32 << 12) | (g32 << 2);
            res.bytes = {32'd0, mem32(c1, be)};
            res.count = 4'd4;
         end
         FMT_RGB12_PACK_BE: begin
            // green and blue trade places in this layout: blue is packed before green
            phase_in  = phase_ff + 3'd1;
            res.count = 4'd4;
            unique case (phase_ff)
               3'd0: begin
                  c1       = (g32 << 24) | (b32 << 12) | r32;
                  carry_in = g32 >> 8;
               end
               3'd1: begin
                  c1       = (g32 << 28) | (b32 << 16) | (r32 << 4) | carry_ff;
                  carry_in = g32 >> 4;
               end
               3'd2: begin
                  c1       = (b32 << 20) | (r32 << 8) | carry_ff;
                  carry_in = g32;
               end
               3'd3: begin
                  c1       = (b32 << 24) | (r32 << 12) | carry_ff;
                  carry_in = (g32 << 4) | (b32 >> 8);
               end
               3'd4: begin
                  c1       = (b32 << 28) | (r32 << 16) | carry_ff;
                  carry_in = (g32 << 8) | (b32 >> 4);
               end
               3'd5: begin
                  c1       = (r32 << 20) | carry_ff;
                  carry_in = (g32 << 12) | b32;
               end
               3'd6: begin
                  c1       = (r32 << 24) | carry_ff;
                  carry_in = (g32 << 16) | (b32 << 4) | (r32 >> 8);
               end
               3'd7: begin
                  c1        = (r32 << 28) | carry_ff;
                  c2        = (g32 << 20) | (b32 << 8) | (r32 >> 4);
                  res.count = 4'd8;
               end
            endcase
            res.bytes = {mem32(c2, 1'b1), mem32(c1, 1'b1)};
            if (res.count == 4'd4) begin
               res.bytes[63:32] = 32'd0;
            end
         end
         FMT_RGB12_FILL_BE, FMT_RGB12_FILL_LE: begin
            be        = (head.fmt == FMT_RGB12_FILL_BE);
            res.bytes = {16'd0, mem16({gc[11:0], 4'd0}, be), mem16({bc[11:0], 4'd0}, be),
                         mem16({rc[11:0], 4'd0}, be)};
            res.count = 4'd6;
         end
         FMT_RGBA12_FILL_BE, FMT_RGBA12_FILL_LE: begin
            be        = (head.fmt == FMT_RGBA12_FILL_BE);
            res.bytes = {mem16({ac[11:0], 4'd0}, be), mem16({bc[11:0], 4'd0}, be),
                         mem16({gc[11:0], 4'd0}, be), mem16({rc[11:0], 4'd0}, be)};
            res.count = 4'd8;
         end
         FMT_RGB16_BE, FMT_RGB16_LE: begin
            be        = (head.fmt == FMT_RGB16_BE);
            res.bytes = {16'd0, mem16(bc, be), mem16(gc, be), mem16(rc, be)};
            res.count = 4'd6;
         end
         FMT_RGBA16_BE, FMT_RGBA16_LE: begin
            be        = (head.fmt == FMT_RGBA16_BE);
            res.bytes = {mem16(ac, be), mem16(bc, be), mem16(gc, be), mem16(rc, be)};
            res.count = 4'd8;
         end
         FMT_RGBA10_LE, FMT_RGBA10_BE: begin
            be = (head.fmt == FMT_RGBA10_BE);
            // treat a phase of 3 or more, left over from another layout, as the group start
            ph3 = (phase_ff < 3'd3) ? phase_ff[1:0] : 2'd0;
            phase_in  = (ph3 == 2'd2) ? 3'd0 : {1'b0, ph3 + 2'd1};
            res.count = 4'd4;
            if (ph3 == 2'd0) begin
               c1       = (r32 << 22) | (g32 << 12) | (b32 << 2);
               carry_in = a32 << 22;
            end else if (ph3 == 2'd1) begin
               c1       = carry_ff | (r32 << 12) | (g32 << 2);
               carry_in = (b32 << 22) | (a32 << 12);
            end else begin
               c1        = carry_ff | (r32 << 2);
               c2        = (g32 << 22) | (b32 << 12) | (a32 << 2);
               res.count = 4'd8;
            end
            res.bytes = {mem32(c2, be), mem32(c1, be)};
            if (res.count == 4'd4) begin
               res.bytes[63:32] = 32'd0;
            end
         end
         FMT_RGBA12_PACK_BE: begin
            if (phase_ff == 3'd1) begin
               phase_in  = 3'd0;
               c1        = (g32 << 28) | (r32 << 16) | carry_ff;
               c2        = (a32 << 20) | (b32 << 8) | (g32 >> 4);
               res.bytes = {mem32(c2, 1'b1), mem32(c1, 1'b1)};
               res.count = 4'd8;
            end else begin
               phase_in  = 3'd1;
               c1        = (b32 << 24) | (g32 << 12) | r32;
               carry_in  = (a32 << 4) | (b32 >> 8);
               res.bytes = {32'd0, mem32(c1, 1'b1)};
               res.count = 4'd4;
            end
         end
      endcase

      // drop any partial group at the end of a line
      if (head.eol) begin
         phase_in = 3'd0;
      end
   end

   always_comb begin
      count_in = count_ff + {1'b0, head_pop} - {1'b0, do_rsp_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 3'd0;
         carry_ff  <= 32'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (head_pop) begin
            phase_ff  <= phase_in;
            carry_ff  <= carry_in;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rsp_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         obuf_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// ----- src/inverse_rct_dpx_pixel_packer_core.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         push / full          g_in, b_in, r_in, a_in, end_of_line
// rsp_      out        empty / pop          packed_bytes, byte_count, line_done
// csr_      in         wr_en, no wait       index, wdata (sample_bits, pixel_format)
//
// One pixel per clock sustained while the rsp side keeps popping; the packer's output queue
// lets a new pixel in while a result waits. A result reaches the rsp ports through
// registered queues in turn: the pixel is held in the pixel queue behind the combinational
// colour front end, then the packer writes its result into the output queue.
// Synchronous reset clears both queues, the packing phase, the carried bits and the
// registers (sample_bits 10, layout RGB 10-bit LE). A stalled rsp side fills the output
// queue, then the pixel queue, and then raises req_full.
module inverse_rct_dpx_pixel_packer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_g_in,
   input  logic [16:0] req_b_in,
   input  logic [16:0] req_r_in,
   input  logic [15:0] req_a_in,
   input  logic        req_end_of_line,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_packed_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_line_done,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   import irct_pkg::*;

   pixel_type  front_pixel;
   pixel_type  queue_head;
   logic       queue_empty;
   logic       queue_pop;
   result_type rsp_item;

   irct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .g_sample  (req_g_in),
      .b_sample  (req_b_in),
      .r_sample  (req_r_in),
      .a_sample  (req_a_in),
      .eol       (req_end_of_line),
      .pixel     (front_pixel)
   );

   irct_pix_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_pixel),
      .full      (req_full),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   irct_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .head_empty (queue_empty),
      .head_pop   (queue_pop),
      .rsp_item   (rsp_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_packed_bytes = rsp_item.bytes;
   assign rsp_byte_count   = rsp_item.count;
   assign rsp_line_done    = rsp_item.eol;

endmodule
